@@ rtl/rtt_pkg.sv @@
// types, codes and field layout shared by the ranging timestamp table
`timescale 1ns / 1ps

package rtt_pkg;

   // fixed field widths
   localparam int TIME_W   = 40;
   localparam int FLIGHT_W = 32;
   localparam int SEQ_W    = 16;
   localparam int CMD_W    = 2;
   localparam int INDEX_W  = 4;
   localparam int STATUS_W = 2;

   localparam int DEFAULT_TABLE_DEPTH = 16;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;
   // spare code, answered with no entry and no state change
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_HIT  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DONE = 2'd2;

   // request payload, last member in the lowest bits
   typedef struct packed {
      logic [TIME_W-1:0]          query_time;
      logic                       role;
      logic [SEQ_W-1:0]           peer_seq;
      logic [SEQ_W-1:0]           own_seq;
      logic signed [FLIGHT_W-1:0] flight_time;
      logic                       rx_present;
      logic [TIME_W-1:0]          rx_time;
      logic                       tx_present;
      logic [TIME_W-1:0]          tx_time;
   } req_type;

   // response payload, last member in the lowest bits
   typedef struct packed {
      logic signed [FLIGHT_W-1:0] found_flight_time;
      logic [TIME_W-1:0]          found_rx_time;
      logic [TIME_W-1:0]          found_tx_time;
      logic [INDEX_W-1:0]         result_index;
   } rsp_type;

   // one stored ranging record
   typedef struct packed {
      logic                       tx_ok;
      logic [TIME_W-1:0]          tx;
      logic                       rx_ok;
      logic [TIME_W-1:0]          rx;
      logic signed [FLIGHT_W-1:0] flight;
      logic [SEQ_W-1:0]           own;
      logic [SEQ_W-1:0]           peer;
   } rec_type;

   localparam int REQ_FIELDS_W = $bits(req_type);
   localparam int RSP_FIELDS_W = $bits(rsp_type);
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

endpackage

@@ rtl/ranging_timestamp_table.sv @@
// ranging timestamp table: recency-ordered record list with add, search and find
`timescale 1ns / 1ps

// Keeps up to TABLE_DEPTH ranging records as a linked list, newest first, in
// on-chip memories with one read port each. One transaction is worked on at a
// time: req_tready is high only while the table is idle. Each command walks
// the list one entry per clock, limited by the single read port of the record
// memory. A command visits at most TABLE_DEPTH entries. One that ends in the
// walk passes its result on to the output stage; a search that finds a record
// first reads it once more, an add that creates one goes through the insert
// steps, and an add on a full table first evicts the oldest record. A stalled
// response channel holds the result back. A finished result waits in an output
// register until taken, and the next transaction is accepted meanwhile. No
// clearing pass follows reset.
module ranging_timestamp_table #(
   parameter int TABLE_DEPTH = rtt_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   // request transaction
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tx_time, tx_present, rx_time, rx_present, flight_time, own_seq,
   // peer_seq, role, query_time, zero padding
   input  logic [rtt_pkg::REQ_DATA_W-1:0]     req_tdata,
   // command
   input  logic [rtt_pkg::CMD_W-1:0]          req_tuser,
   // response transaction
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // result_index, found_tx_time, found_rx_time, found_flight_time,
   // zero padding
   output logic [rtt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // result_status
   output logic [rtt_pkg::STATUS_W-1:0]       rsp_tuser
);
   import rtt_pkg::*;

   localparam int SLOT_W = $clog2(TABLE_DEPTH);
   localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
   localparam int LINK_W = SLOT_W + 1;
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TABLE_DEPTH);
   localparam logic [LINK_W-1:0] LINK_NULL = '0;

   // sequencer states
   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_WALK       = 4'd1;
   localparam logic [3:0] S_EVICT_RD   = 4'd2;
   localparam logic [3:0] S_EVICT      = 4'd3;
   localparam logic [3:0] S_INS_A      = 4'd4;
   localparam logic [3:0] S_INS_B      = 4'd5;
   localparam logic [3:0] S_FETCH      = 4'd6;
   localparam logic [3:0] S_FETCH_WAIT = 4'd7;
   localparam logic [3:0] S_EMIT       = 4'd8;

   // control registers
   logic [3:0]          state_ff, state_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [SLOT_W-1:0]   head_ff, head_in;
   logic [SLOT_W-1:0]   tail_ff, tail_in;
   logic                head_valid_ff, head_valid_in;
   logic                best_valid_ff, best_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload registers
   req_type             req_ff, req_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [SLOT_W-1:0]   cur_ff, cur_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [SLOT_W-1:0]   best_ff, best_in;
   logic [TIME_W-1:0]   best_key_ff, best_key_in;
   rsp_type             res_ff, res_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // memories and their ports
   rec_type             rec_mem [TABLE_DEPTH];
   logic [LINK_W-1:0]   next_mem [TABLE_DEPTH];
   logic [LINK_W-1:0]   prev_mem [TABLE_DEPTH];
   rec_type             rec_rd_ff;
   logic [LINK_W-1:0]   next_rd_ff;
   logic [LINK_W-1:0]   prev_rd_ff;
   logic [SLOT_W-1:0]   rd_addr;
   logic                rec_we, next_we, prev_we;
   logic [SLOT_W-1:0]   rec_waddr, next_waddr, prev_waddr;
   rec_type             rec_wdata;
   logic [LINK_W-1:0]   next_wdata, prev_wdata;

   // helpers
   rec_type             new_rec;
   rec_type             upd_rec;
   logic [TIME_W-1:0]   key;
   logic                cand;
   logic                ins_start;
   logic                out_free;
   logic [SLOT_W-1:0]   next_slot;
   logic                next_valid;

   function automatic rsp_type hit_payload(logic [SLOT_W-1:0] s, rec_type r);
      rsp_type p;
      p.result_index      = INDEX_W'(s);
      p.found_tx_time     = r.tx_ok ? r.tx : '0;
      p.found_rx_time     = r.rx_ok ? r.rx : '0;
      p.found_flight_time = r.flight;
      return p;
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}}, rsp_data_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign next_slot  = next_rd_ff[SLOT_W-1:0];
   assign next_valid = next_rd_ff[SLOT_W];

   // record built from the request for a fresh entry
   always_comb begin
      new_rec.tx_ok  = req_ff.tx_present;
      new_rec.tx     = req_ff.tx_time;
      new_rec.rx_ok  = req_ff.rx_present;
      new_rec.rx     = req_ff.rx_time;
      new_rec.flight = req_ff.flight_time;
      new_rec.own    = req_ff.own_seq;
      new_rec.peer   = req_ff.peer_seq;
   end

   // record completed in place by an add
   always_comb begin
      upd_rec       = rec_rd_ff;
      upd_rec.tx_ok = req_ff.tx_present;
      upd_rec.tx    = req_ff.tx_time;
      upd_rec.peer  = req_ff.peer_seq;
   end

   // search compare on the entry being visited
   assign key  = req_ff.role ? rec_rd_ff.rx : rec_rd_ff.tx;
   assign cand = rec_rd_ff.tx_ok && rec_rd_ff.rx_ok && (key < req_ff.query_time) &&
                 (!best_valid_ff || (key > best_key_ff));

   // read address of the record and next-link memories
   always_comb begin
      priority if (state_ff == S_IDLE) begin
         rd_addr = head_ff;
      end else if (state_ff == S_WALK) begin
         rd_addr = next_slot;
      end else begin
         rd_addr = best_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      head_valid_in = head_valid_ff;
      best_valid_in = best_valid_ff;
      req_in        = req_ff;
      cmd_in        = cmd_ff;
      cur_in        = cur_ff;
      slot_in       = slot_ff;
      best_in       = best_ff;
      best_key_in   = best_key_ff;
      res_in        = res_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rec_we        = 1'b0;
      rec_waddr     = cur_ff;
      rec_wdata     = upd_rec;
      next_we       = 1'b0;
      next_waddr    = slot_ff;
      next_wdata    = LINK_NULL;
      prev_we       = 1'b0;
      prev_waddr    = slot_ff;
      prev_wdata    = LINK_NULL;
      ins_start     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               req_in        = req_type'(req_tdata[REQ_FIELDS_W-1:0]);
               cmd_in        = req_tuser;
               cur_in        = head_ff;
               best_valid_in = 1'b0;
               res_in        = '0;
               res_status_in = ST_NONE;
               unique case (req_tuser)
                  CMD_ADD: begin
                     if (head_valid_ff) begin
                        state_in = S_WALK;
                     end else begin
                        ins_start = 1'b1;
                     end
                  end
                  CMD_SEARCH, CMD_FIND: begin
                     state_in = head_valid_ff ? S_WALK : S_EMIT;
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_WALK: begin
            cur_in = next_slot;
            unique case (cmd_ff)
               CMD_ADD: begin
                  if (rec_rd_ff.own == req_ff.peer_seq) begin
                     rec_we        = 1'b1;
                     res_in        = hit_payload(cur_ff, upd_rec);
                     res_status_in = ST_HIT;
                     state_in      = S_EMIT;
                  end else if (!next_valid) begin
                     ins_start = 1'b1;
                  end
               end
               CMD_SEARCH: begin
                  if (cand) begin
                     best_in       = cur_ff;
                     best_key_in   = key;
                     best_valid_in = 1'b1;
                  end
                  if (!next_valid) begin
                     state_in = (cand || best_valid_ff) ? S_FETCH : S_EMIT;
                  end
               end
               default: begin
                  // find: an already processed remote sequence wins over a local match
                  if (rec_rd_ff.peer == req_ff.peer_seq) begin
                     res_status_in = ST_DONE;
                     state_in      = S_EMIT;
                  end else if (rec_rd_ff.own == req_ff.peer_seq) begin
                     res_in        = hit_payload(cur_ff, rec_rd_ff);
                     res_status_in = ST_HIT;
                     state_in      = S_EMIT;
                  end else if (!next_valid) begin
                     state_in = S_EMIT;
                  end
               end
            endcase
         end
         S_EVICT_RD: begin
            state_in = S_EVICT;
         end
         S_EVICT: begin
            // unlink the oldest record, its slot is reused at once
            tail_in    = prev_rd_ff[SLOT_W-1:0];
            next_we    = 1'b1;
            next_waddr = prev_rd_ff[SLOT_W-1:0];
            next_wdata = LINK_NULL;
            state_in   = S_INS_A;
         end
         S_INS_A: begin
            rec_we     = 1'b1;
            rec_waddr  = slot_ff;
            rec_wdata  = new_rec;
            next_we    = 1'b1;
            next_waddr = slot_ff;
            next_wdata = head_valid_ff ? {1'b1, head_ff} : LINK_NULL;
            prev_we    = 1'b1;
            prev_waddr = slot_ff;
            prev_wdata = LINK_NULL;
            state_in   = S_INS_B;
         end
         S_INS_B: begin
            prev_we       = head_valid_ff;
            prev_waddr    = head_ff;
            prev_wdata    = {1'b1, slot_ff};
            head_in       = slot_ff;
            if (!head_valid_ff) begin
               tail_in = slot_ff;
            end
            head_valid_in = 1'b1;
            res_in        = hit_payload(slot_ff, new_rec);
            res_status_in = ST_HIT;
            state_in      = S_EMIT;
         end
         S_FETCH: begin
            state_in = S_FETCH_WAIT;
         end
         S_FETCH_WAIT: begin
            res_in        = hit_payload(best_ff, rec_rd_ff);
            res_status_in = ST_HIT;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // slot for a new record: next unused one, else the oldest
      if (ins_start) begin
         if (fill_ff != FILL_FULL) begin
            slot_in  = fill_ff[SLOT_W-1:0];
            fill_in  = fill_ff + FILL_W'(1);
            state_in = S_INS_A;
         end else begin
            slot_in  = tail_ff;
            state_in = S_EVICT_RD;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         head_valid_ff <= 1'b0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         head_valid_ff <= head_valid_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      cmd_ff        <= cmd_in;
      cur_ff        <= cur_in;
      slot_ff       <= slot_in;
      best_ff       <= best_in;
      best_key_ff   <= best_key_in;
      res_ff        <= res_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   // record memory
   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[rec_waddr] <= rec_wdata;
      end
      rec_rd_ff <= rec_mem[rd_addr];
   end

   // next-link memory
   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      next_rd_ff <= next_mem[rd_addr];
   end

   // previous-link memory, read at the tail for eviction
   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      prev_rd_ff <= prev_mem[tail_ff];
   end

`ifndef SYNTHESIS
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("fill count beyond table depth");

   // the fill count runs ahead of the head flag during an insert
   a_head_matches_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> head_valid_ff == (fill_ff != '0))
      else $error("list head flag disagrees with fill count");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_HIT) |-> rsp_data_ff == '0)
      else $error("non-hit response carries payload");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a transaction is in progress");
`endif

endmodule
